// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer to ASCII formatter
// Format codes, character codes, sequencer states and the character record.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // format commands
  localparam logic [2:0] CMD_U8_DEC  = 3'd0;
  localparam logic [2:0] CMD_S8_DEC  = 3'd1;
  localparam logic [2:0] CMD_U16_DEC = 3'd2;
  localparam logic [2:0] CMD_S16_DEC = 3'd3;
  localparam logic [2:0] CMD_U8_BIN  = 3'd4;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // BCD conversion geometry
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned DIGITS  = 5;
  localparam int unsigned BCD_W   = 4 * DIGITS;

  // digit index of the hundreds place (first place of an 8-bit value)
  localparam logic [2:0] FIRST_POS_8  = 3'd2;
  localparam logic [2:0] FIRST_POS_16 = 3'd0;
  localparam logic [2:0] UNITS_POS    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS,
    ST_BITS
  } state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_t;

endpackage

// ===== src/itoa_if.sv =====
// ----------------------------------------------------------------------------
// itoa_if: channel interfaces of the integer to ASCII formatter
// Number channel (format + value) and character channel (char + last mark).
// ----------------------------------------------------------------------------
interface itoa_num_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface itoa_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== src/itoa_bcd.sv =====
// ----------------------------------------------------------------------------
// itoa_bcd: iterative binary to BCD converter
// Shift-and-add-3 over the 16 input bits, one bit per cycle.
// ----------------------------------------------------------------------------
module itoa_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [itoa_pkg::BIN_W-1:0]    bin_i,
  output logic                          done_o,
  output logic [itoa_pkg::BCD_W-1:0]    bcd_o
);

  logic [itoa_pkg::BIN_W-1:0] bin_q, bin_d;
  logic [itoa_pkg::BCD_W-1:0] bcd_q, bcd_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [itoa_pkg::BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(itoa_pkg::DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[itoa_pkg::BCD_W-2:0], bin_q[itoa_pkg::BIN_W-1]};
      bin_d = {bin_q[itoa_pkg::BIN_W-2:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(itoa_pkg::BIN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== src/itoa_out_reg.sv =====
// ----------------------------------------------------------------------------
// itoa_out_reg: character output register
// Holds one character until the receiver takes it; frees the slot on transfer.
// ----------------------------------------------------------------------------
module itoa_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  itoa_pkg::char_t       data_i,
  output logic                  free_o,
  itoa_char_if.source           char_o
);

  logic            valid_q;
  itoa_pkg::char_t data_q;

  assign free_o = !valid_q || char_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (char_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign char_o.valid     = valid_q;
  assign char_o.char_code = data_q.char_code;
  assign char_o.last      = data_q.last;

endmodule

// ===== src/integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: integer to ASCII character formatter
// Turns a 16-bit value and a format command into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one number: cmd picks the format (u8/s8/u16/s16 decimal,
//   u8 binary) and value the raw bits. char_o returns the characters one per
//   transfer, most significant first, with last set on the final one.
//   Decimal output drops leading zeros, always keeps the units digit, and a
//   negative signed value starts with '-'. Commands 5..7 are taken and
//   produce no characters.
// Timing:
//   item_i.ready is high only while the sequencer is idle. A decimal number
//   is accepted, runs through the shift-and-add-3 converter, has its first
//   digit picked, then sends one character per cycle while the receiver
//   does not stall. Binary is accepted, then sends its eight bits at the
//   same rate. The converter loop (one bit a cycle) sets the decimal latency.
// Reset and stalls:
//   Reset returns the sequencer to idle and empties the output register.
//   When char_o.ready is low the sequencer holds at the current character;
//   the last character sits in the output register while the next number is
//   already accepted.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_num_if.sink    item_i,
  itoa_char_if.source char_o
);

  itoa_pkg::state_e state_q, state_d;

  logic [2:0] pos_q, pos_d;      // decimal digit place being sent
  logic [2:0] cnt_q, cnt_d;      // binary bit count
  logic [7:0] bits_q, bits_d;    // binary shift register, MSB sent first
  logic       neg_q, neg_d;
  logic       short_q, short_d;  // 8-bit decimal format

  // converter
  logic                             bcd_start;
  logic [itoa_pkg::BIN_W-1:0]       bcd_bin;
  logic                             bcd_done;
  logic [itoa_pkg::BCD_W-1:0]       bcd;

  // output register
  logic            push;
  logic            out_free;
  itoa_pkg::char_t push_data;

  // first digit and current digit
  logic [2:0] first_pos;
  logic [2:0] start_pos;
  logic [3:0] digit;

  // magnitude and sign of the incoming number
  logic [7:0]  lo;
  logic [15:0] mag;
  logic        neg_in;

  assign lo = item_i.value[7:0];

  always_comb begin
    neg_in = 1'b0;
    mag    = {8'd0, lo};
    case (item_i.cmd)
      itoa_pkg::CMD_U8_DEC: begin
        mag = {8'd0, lo};
      end
      itoa_pkg::CMD_S8_DEC: begin
        neg_in = lo[7];
        // -128 negates to 0x80, its true magnitude
        mag = lo[7] ? {8'd0, 8'(-lo)} : {8'd0, lo};
      end
      itoa_pkg::CMD_U16_DEC: begin
        mag = item_i.value;
      end
      itoa_pkg::CMD_S16_DEC: begin
        neg_in = item_i.value[15];
        mag    = item_i.value[15] ? 16'(-item_i.value) : item_i.value;
      end
      default: begin
        mag = {8'd0, lo};
      end
    endcase
  end

  assign bcd_bin = mag;

  itoa_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (bcd_bin),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  // leading zero suppression: most significant nonzero place at or after the format's
  // first place, else the units place
  assign first_pos = short_q ? itoa_pkg::FIRST_POS_8 : itoa_pkg::FIRST_POS_16;

  always_comb begin
    start_pos = itoa_pkg::UNITS_POS;
    for (int i = 3; i >= 0; i--) begin
      if ((3'(i) >= first_pos) && (bcd[4*(4-i) +: 4] != 4'd0)) begin
        start_pos = 3'(i);
      end
    end
  end

  always_comb begin
    case (pos_q)
      3'd0:    digit = bcd[19:16];
      3'd1:    digit = bcd[15:12];
      3'd2:    digit = bcd[11:8];
      3'd3:    digit = bcd[7:4];
      default: digit = bcd[3:0];
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    bits_d    = bits_q;
    neg_d     = neg_q;
    short_d   = short_q;
    bcd_start = 1'b0;
    push      = 1'b0;
    push_data = '{char_code: itoa_pkg::CH_ZERO, last: 1'b0};
    item_i.ready = 1'b0;

    case (state_q)
      itoa_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          neg_d   = neg_in;
          short_d = (item_i.cmd == itoa_pkg::CMD_U8_DEC) ||
                    (item_i.cmd == itoa_pkg::CMD_S8_DEC);
          if (item_i.cmd == itoa_pkg::CMD_U8_BIN) begin
            bits_d  = lo;
            cnt_d   = '0;
            state_d = itoa_pkg::ST_BITS;
          end else if ((item_i.cmd == itoa_pkg::CMD_U8_DEC) ||
                       (item_i.cmd == itoa_pkg::CMD_S8_DEC) ||
                       (item_i.cmd == itoa_pkg::CMD_U16_DEC) ||
                       (item_i.cmd == itoa_pkg::CMD_S16_DEC)) begin
            bcd_start = 1'b1;
            state_d   = itoa_pkg::ST_CONV;
          end
        end
      end

      itoa_pkg::ST_CONV: begin
        if (bcd_done) begin
          pos_d   = start_pos;
          state_d = neg_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGITS;
        end
      end

      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{char_code: itoa_pkg::CH_MINUS, last: 1'b0};
          state_d   = itoa_pkg::ST_DIGITS;
        end
      end

      itoa_pkg::ST_DIGITS: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{char_code: itoa_pkg::CH_ZERO + {4'd0, digit},
                        last: (pos_q == itoa_pkg::UNITS_POS)};
          pos_d     = pos_q + 3'd1;
          if (pos_q == itoa_pkg::UNITS_POS) begin
            state_d = itoa_pkg::ST_IDLE;
          end
        end
      end

      itoa_pkg::ST_BITS: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{char_code: itoa_pkg::CH_ZERO + {7'd0, bits_q[7]},
                        last: (cnt_q == 3'd7)};
          bits_d    = {bits_q[6:0], 1'b0};
          cnt_d     = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_d = itoa_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      short_q <= short_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  itoa_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .free_o (out_free),
    .char_o (char_o)
  );

endmodule

// ===== bench/integer_to_ascii_formatter_top_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top_tb: self-checking bench of the ASCII formatter
// Sends numbers in every format. A short table of known cases comes first,
// then random numbers biased to decimal boundaries. Each character is checked
// in order against the table text or local formatter; both handshakes stall at random.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // commands the block takes but answers with nothing
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int NUM_RANDOM   = 450;
  localparam int IDLE_PCT     = 14;   // idle cycles per hundred, each side
  localparam int QUIET_FIRST  = 200;  // random items with no idling at all
  localparam int QUIET_LAST   = 299;
  localparam int PAUSE_AT     = 120;  // sender waits for the character stream to drain
  localparam int DRAIN_CYCLES = 64;   // well over one decimal conversion
  localparam int CYCLE_LIMIT  = 250000;

  // one row of the directed table; fixed rows carry the text by hand,
  // the rest go through the local formatter
  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] value;
    bit          fixed;
    string       text;
  } dir_row_t;

  // one character still to come, with the number it belongs to
  typedef struct {
    itoa_pkg::char_t ch;
    int              num_idx;
  } pending_char_t;

  localparam int NUM_DIR = 25;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{itoa_pkg::CMD_U8_DEC,  16'h0000, 1'b1, "0"},
    '{itoa_pkg::CMD_U8_DEC,  16'h00FF, 1'b1, "255"},
    '{itoa_pkg::CMD_U8_DEC,  16'hFF00, 1'b1, "0"},        // upper byte ignored
    '{itoa_pkg::CMD_U8_DEC,  16'h0064, 1'b0, ""},
    '{itoa_pkg::CMD_S8_DEC,  16'h007F, 1'b1, "127"},
    '{itoa_pkg::CMD_S8_DEC,  16'h0080, 1'b1, "-128"},     // most negative byte
    '{itoa_pkg::CMD_S8_DEC,  16'h00FF, 1'b1, "-1"},
    '{itoa_pkg::CMD_S8_DEC,  16'hAB00, 1'b1, "0"},
    '{itoa_pkg::CMD_S8_DEC,  16'h0085, 1'b0, ""},
    '{itoa_pkg::CMD_U16_DEC, 16'h0000, 1'b1, "0"},
    '{itoa_pkg::CMD_U16_DEC, 16'hFFFF, 1'b1, "65535"},
    '{itoa_pkg::CMD_U16_DEC, 16'h2710, 1'b1, "10000"},
    '{itoa_pkg::CMD_U16_DEC, 16'h0009, 1'b0, ""},
    '{itoa_pkg::CMD_U16_DEC, 16'h04D2, 1'b0, ""},
    '{itoa_pkg::CMD_S16_DEC, 16'h7FFF, 1'b1, "32767"},
    '{itoa_pkg::CMD_S16_DEC, 16'h8000, 1'b1, "-32768"},   // most negative word
    '{itoa_pkg::CMD_S16_DEC, 16'hFFFF, 1'b1, "-1"},
    '{itoa_pkg::CMD_S16_DEC, 16'hFF85, 1'b0, ""},
    '{itoa_pkg::CMD_U8_BIN,  16'h0000, 1'b1, "00000000"},
    '{itoa_pkg::CMD_U8_BIN,  16'h00FF, 1'b1, "11111111"},
    '{itoa_pkg::CMD_U8_BIN,  16'hFF5A, 1'b1, "01011010"},
    '{itoa_pkg::CMD_U8_BIN,  16'h00A5, 1'b0, ""},
    '{CMD_RSVD5,             16'h1234, 1'b1, ""},         // unused formats: no characters
    '{CMD_RSVD6,             16'hFFFF, 1'b1, ""},
    '{CMD_RSVD7,             16'h0000, 1'b1, ""}
  };

  logic clk_i;
  logic rst_ni;

  itoa_num_if  num_if ();
  itoa_char_if char_if ();

  integer_to_ascii_formatter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (num_if),
    .char_o (char_if)
  );

  pending_char_t pending_chars[$];
  int            num_accepted;
  int            chars_checked;
  int            mismatches;
  int            per_format[8];
  int            cycle_count;
  bit            quiet;           // both sides stop idling while set
  bit            sender_done;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Local formatter: the characters one number must produce
  // --------------------------------------------------------------------------
  function automatic void predict_chars(input logic [2:0] cmd, input logic [15:0] value,
                                        output itoa_pkg::char_t chars[$]);
    int unsigned     place [5] = '{10000, 1000, 100, 10, 1};
    int unsigned     mag;
    int unsigned     digit;
    int              first_place;
    bit              negative;
    bit              started;
    itoa_pkg::char_t ch;
    chars       = {};
    negative    = 1'b0;
    started     = 1'b0;
    first_place = 0;
    mag         = 0;
    ch.last     = 1'b0;
    case (cmd)
      itoa_pkg::CMD_U8_DEC: begin
        mag = value[7:0];
        first_place = 2;
      end
      itoa_pkg::CMD_S8_DEC: begin
        negative = value[7];
        mag = negative ? 32'h100 - value[7:0] : value[7:0];
        first_place = 2;
      end
      itoa_pkg::CMD_U16_DEC: begin
        mag = value;
      end
      itoa_pkg::CMD_S16_DEC: begin
        negative = value[15];
        mag = negative ? 32'h10000 - value : value;
      end
      itoa_pkg::CMD_U8_BIN: begin
        for (int b = 7; b >= 0; b--) begin
          ch.char_code = itoa_pkg::CH_ZERO + 8'(value[b]);
          chars.push_back(ch);
        end
      end
      default: begin
        return;   // unused formats answer with nothing
      end
    endcase
    if (cmd != itoa_pkg::CMD_U8_BIN) begin
      if (negative) begin
        ch.char_code = itoa_pkg::CH_MINUS;
        chars.push_back(ch);
      end
      // leading zeros dropped, units digit always kept
      for (int p = first_place; p < 5; p++) begin
        digit = mag / place[p];
        mag   = mag - digit * place[p];
        if (digit != 0 || started || p == 4) begin
          started = 1'b1;
          ch.char_code = itoa_pkg::CH_ZERO + 8'(digit);
          chars.push_back(ch);
        end
      end
    end
    chars[chars.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one number per transfer on num_if
  // --------------------------------------------------------------------------
  // Called with valid possibly still high from the previous transfer; valid
  // gets exactly one assignment per clock edge.
  task automatic send_number(input logic [2:0] cmd, input logic [15:0] value,
                             input bit use_text, input string text);
    itoa_pkg::char_t chars[$];
    itoa_pkg::char_t ch;
    pending_char_t   entry;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      num_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    num_if.valid <= 1'b1;
    num_if.cmd   <= cmd;
    num_if.value <= value;
    do @(posedge clk_i); while (!num_if.ready);
    // transfer taken at this edge
    if (use_text) begin
      chars = {};
      for (int i = 0; i < text.len(); i++) begin
        ch.char_code = text[i];
        ch.last      = (i == text.len() - 1);
        chars.push_back(ch);
      end
    end else begin
      predict_chars(cmd, value, chars);
    end
    foreach (chars[i]) begin
      entry.ch      = chars[i];
      entry.num_idx = num_accepted;
      pending_chars.push_back(entry);
    end
    per_format[cmd]++;
    num_accepted++;
  endtask

  // lower valid and hold until every character already owed has arrived;
  // at least one edge passes so valid is not assigned twice in one step
  task automatic wait_drained();
    num_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // random value biased toward sign bits and decimal place boundaries
  function automatic logic [15:0] pick_value();
    logic [15:0] edges [16] = '{16'd9, 16'd10, 16'd99, 16'd100, 16'd127, 16'd128,
                                16'd255, 16'd256, 16'd999, 16'd1000, 16'd9999,
                                16'd10000, 16'd32767, 16'd32768, 16'd65535, 16'd1};
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(9))
      0: v = 16'($urandom_range(0, 12));
      1: v = edges[$urandom_range(0, 15)];
      2: v[7:0] = 8'($urandom_range(8'h7E, 8'h81));
      3: v = 16'hFFFF - 16'($urandom_range(0, 200));
      4: v = 16'h8000 + 16'($urandom_range(0, 200));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [2:0]  cmd;
    logic [15:0] value;
    num_if.valid = 1'b0;
    num_if.cmd   = itoa_pkg::CMD_U8_DEC;
    num_if.value = '0;
    quiet        = 1'b0;
    sender_done  = 1'b0;
    num_accepted = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < NUM_DIR; r++)
      send_number(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].fixed, dir_rows[r].text);
    wait_drained();

    // random numbers; unused formats are rare noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
      if (n == PAUSE_AT) wait_drained();
      if ($urandom_range(99) < 5)
        cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      else
        cmd = 3'($urandom_range(itoa_pkg::CMD_U8_DEC, itoa_pkg::CMD_U8_BIN));
      value = pick_value();
      send_number(cmd, value, 1'b0, "");
    end
    quiet = 1'b0;
    num_if.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls on char_if, in-order check of every character
  // --------------------------------------------------------------------------
  initial begin
    pending_char_t want;
    char_if.ready = 1'b0;
    chars_checked = 0;
    mismatches    = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      // values seen here are the ones the edge sampled
      if (char_if.valid && char_if.ready) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h last=%0b with nothing owed",
                                    char_if.char_code, char_if.last));
        end else begin
          want = pending_chars.pop_front();
          if (char_if.char_code !== want.ch.char_code)
            report_mismatch($sformatf("number %0d: char 0x%02h, expected 0x%02h",
                                      want.num_idx, char_if.char_code, want.ch.char_code));
          if (char_if.last !== want.ch.last)
            report_mismatch($sformatf("number %0d: last %0b, expected %0b",
                                      want.num_idx, char_if.last, want.ch.last));
        end
      end
      char_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    wait (sender_done);
    while (pending_chars.size() != 0) @(posedge clk_i);
    // catch any stray characters after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d numbers: u8 %0d, s8 %0d, u16 %0d, s16 %0d, bin %0d, unused %0d",
             num_accepted, per_format[itoa_pkg::CMD_U8_DEC],
             per_format[itoa_pkg::CMD_S8_DEC], per_format[itoa_pkg::CMD_U16_DEC],
             per_format[itoa_pkg::CMD_S16_DEC], per_format[itoa_pkg::CMD_U8_BIN],
             per_format[CMD_RSVD5] + per_format[CMD_RSVD6] + per_format[CMD_RSVD7]);
    $display("Checked %0d characters, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS integer_to_ascii_formatter_top");
    end else begin
      $display("FAIL integer_to_ascii_formatter_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d characters still owed",
             cycle_count, pending_chars.size());
    $display("FAIL integer_to_ascii_formatter_top");
    $finish;
  end

endmodule
